// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by gap_branch_predictor.
// Each macro checks one implication on the rising edge of clk and is
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gbp_pkg.sv -----
// ----------------------------------------------------------------------------
// gbp_pkg
// Types and fixed constants of the two-level GAp branch predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package gbp_pkg;

    // Widths of the configuration registers and of the write port.
    localparam int HIST_BITS_W  = 4;
    localparam int CTR_BITS_W   = 4;
    localparam int PCIDX_BITS_W = 3;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 4;

    // Reset values of the configuration registers.
    localparam logic [HIST_BITS_W-1:0]  HIST_BITS_RST  = 4'd8;
    localparam logic [CTR_BITS_W-1:0]   CTR_BITS_RST   = 4'd2;
    localparam logic [PCIDX_BITS_W-1:0] PCIDX_BITS_RST = 3'd6;

    // Stream payload widths.
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;

    // Instruction size used to decide the branch outcome.
    localparam logic [31:0] INSN_BYTES = 32'd4;

    // Register index codes of the configuration port.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HISTORY_BITS  = 2'd0,
        CFG_COUNTER_BITS  = 2'd1,
        CFG_PC_INDEX_BITS = 2'd2
    } cfg_index_t;

    // Branch kinds carried on the request side-band.
    typedef enum logic [1:0] {
        REQ_UNCONDITIONAL = 2'd0,
        REQ_CONDITIONAL   = 2'd1,
        REQ_CALL          = 2'd2,
        REQ_RETURN        = 2'd3
    } req_kind_t;

endpackage

`default_nettype wire

// ----- rtl/gap_branch_predictor.sv -----
// ----------------------------------------------------------------------------
// gap_branch_predictor
// GAp two-level branch predictor: PC bits pick a pattern table, global
// history picks a saturating counter in it; also keeps saturating totals.
// ----------------------------------------------------------------------------
// Path: a conditional request enters the read stage as its counter is read;
//   the counter is then updated, written back and loaded into the output
//   register when that register is free.
// Throughput: one request per cycle unless the output stalls; a counter written
//   while the next request reads the same entry is forwarded around the memory.
// Reset: history, totals and configuration reset at once; the counter memory
//   is then cleared one entry a cycle, while s_tready stays low, over all
//   2^(MAX_PC_INDEX_BITS+MAX_HISTORY_BITS) entries.
`default_nettype none

module gap_branch_predictor #(
    parameter int MAX_HISTORY_BITS  = 8,
    parameter int MAX_PC_INDEX_BITS = 6,
    parameter int MAX_COUNTER_BITS  = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Configuration write port.
    input  wire logic                             cfg_we,
    input  wire logic [gbp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [gbp_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Request stream.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [31:0] branch_pc, [63:32] next_pc
    input  wire logic [gbp_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] req_type
    input  wire logic [gbp_pkg::S_TUSER_W-1:0]    s_tuser,
    // Result stream.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [0] predicted_taken, [1] actual_taken, [2] mispredicted,
    // [34:3] branch_total, [66:35] mispredict_total, [71:67] zero
    output logic [gbp_pkg::M_TDATA_W-1:0]         m_tdata
);

    import gbp_pkg::*;

    localparam int HW       = MAX_HISTORY_BITS;
    localparam int CW       = MAX_COUNTER_BITS;
    localparam int CW_IDX_W = (CW > 1) ? $clog2(CW) : 1;
    localparam int ADDR_W   = MAX_PC_INDEX_BITS + MAX_HISTORY_BITS;
    localparam int DEPTH    = 1 << ADDR_W;

    // Configuration registers.
    logic [HIST_BITS_W-1:0]  hist_bits_reg;
    logic [CTR_BITS_W-1:0]   ctr_bits_reg;
    logic [PCIDX_BITS_W-1:0] pcidx_bits_reg;

    // Predictor state.
    logic [HW-1:0]     ghist_reg, ghist_next;
    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // Read stage.
    logic              stg_valid_reg;
    logic [ADDR_W-1:0] stg_addr_reg;
    logic              stg_taken_reg;
    logic              fwd_valid_reg;
    logic [CW-1:0]     fwd_data_reg;

    // Counter memory.
    logic [CW-1:0]     ctr_mem [DEPTH];
    logic [CW-1:0]     mem_q;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CW-1:0]     mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    // Totals and output register.
    logic [31:0] branch_cnt_reg, branch_cnt_next;
    logic [31:0] miss_cnt_reg, miss_cnt_next;
    logic        out_valid_reg;
    logic        out_pred_reg, out_taken_reg, out_miss_reg;

    // Request decode.
    logic [31:0] req_pc, req_npc;
    logic        req_cond, req_taken, accept, stg_fire;

    // Effective widths and masks.
    logic [4:0]          hb_ext, hb_eff;
    logic [3:0]          pb_ext, pb_eff;
    logic [3:0]          cb_eff;
    logic [CW_IDX_W-1:0] cb_top;
    logic [HW-1:0]       hmask, hist_m;
    logic [31:0]         pmask, idx_wide;
    logic [CW-1:0]       cmask, ctr_raw, ctr_m, ctr_new;
    logic                pred, miss;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_bits_reg  <= HIST_BITS_RST;
            ctr_bits_reg   <= CTR_BITS_RST;
            pcidx_bits_reg <= PCIDX_BITS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_HISTORY_BITS:  hist_bits_reg  <= cfg_data[HIST_BITS_W-1:0];
                CFG_COUNTER_BITS:  ctr_bits_reg   <= cfg_data[CTR_BITS_W-1:0];
                CFG_PC_INDEX_BITS: pcidx_bits_reg <= cfg_data[PCIDX_BITS_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the register values to the widths the hardware supports; a counter width of zero is taken as one.
    always_comb
    begin
        hb_ext = {1'b0, hist_bits_reg};
        hb_eff = (hb_ext > 5'(MAX_HISTORY_BITS)) ? 5'(MAX_HISTORY_BITS) : hb_ext;
        pb_ext = {1'b0, pcidx_bits_reg};
        pb_eff = (pb_ext > 4'(MAX_PC_INDEX_BITS)) ? 4'(MAX_PC_INDEX_BITS) : pb_ext;
        if (ctr_bits_reg > 4'(MAX_COUNTER_BITS))
        begin
            cb_eff = 4'(MAX_COUNTER_BITS);
        end
        else if (ctr_bits_reg == 4'd0)
        begin
            cb_eff = 4'd1;
        end
        else
        begin
            cb_eff = ctr_bits_reg;
        end
        cb_top = CW_IDX_W'(cb_eff - 4'd1);
        hmask = ~({HW{1'b1}} << hb_eff);
        pmask = ~(32'hFFFF_FFFF << pb_eff);
        cmask = ~({CW{1'b1}} << cb_eff);
    end

    // Request decode, outcome and memory index.
    assign req_pc    = s_tdata[31:0];
    assign req_npc   = s_tdata[63:32];
    assign req_cond  = (s_tuser == REQ_CONDITIONAL);
    assign req_taken = (req_npc != (req_pc + INSN_BYTES));
    assign hist_m    = ghist_reg & hmask;
    assign idx_wide  = (((req_pc >> 2) & pmask) << MAX_HISTORY_BITS) | 32'(hist_m);

    // Handshakes: the read stage moves on when the output register is free.
    assign stg_fire = stg_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !clr_active_reg && (!stg_valid_reg || stg_fire);
    assign accept   = s_tvalid && s_tready;

    // Global history shifts in the outcome as a conditional request is taken.
    assign ghist_next = ((hist_m << 1) | HW'(req_taken)) & hmask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ghist_reg <= '0;
        end
        else if (accept && req_cond)
        begin
            ghist_reg <= ghist_next;
        end
    end

    // Clearing pass over the counter memory after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == {ADDR_W{1'b1}})
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Counter update of the request in the read stage.
    always_comb
    begin
        ctr_raw = fwd_valid_reg ? fwd_data_reg : mem_q;
        ctr_m   = ctr_raw & cmask;
        pred    = ctr_m[cb_top];
        miss    = pred ^ stg_taken_reg;
        if (stg_taken_reg)
        begin
            ctr_new = (ctr_m < cmask) ? (ctr_m + 1'b1) : ctr_m;
        end
        else
        begin
            ctr_new = (ctr_m != '0) ? (ctr_m - 1'b1) : ctr_m;
        end
    end

    // Memory port selection: clearing writes zeros, otherwise write-back.
    assign mem_we    = clr_active_reg || stg_fire;
    assign mem_waddr = clr_active_reg ? clr_addr_reg : stg_addr_reg;
    assign mem_wdata = clr_active_reg ? '0 : (ctr_new & cmask);
    assign mem_re    = accept && req_cond;
    assign mem_raddr = idx_wide[ADDR_W-1:0];

    // Counter memory, one write and one registered read a cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ctr_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= ctr_mem[mem_raddr];
        end
    end

    // Read stage control and forwarding of a same-entry write-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stg_valid_reg <= req_cond;
            fwd_valid_reg <= stg_fire && (stg_addr_reg == mem_raddr);
        end
        else if (stg_fire)
        begin
            stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_addr_reg  <= mem_raddr;
            stg_taken_reg <= req_taken;
            fwd_data_reg  <= mem_wdata;
        end
    end

    // Saturating totals.
    assign branch_cnt_next = (branch_cnt_reg != 32'hFFFF_FFFF) ?
                             (branch_cnt_reg + 32'd1) : branch_cnt_reg;
    assign miss_cnt_next   = (miss && (miss_cnt_reg != 32'hFFFF_FFFF)) ?
                             (miss_cnt_reg + 32'd1) : miss_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            branch_cnt_reg <= '0;
            miss_cnt_reg   <= '0;
        end
        else if (stg_fire)
        begin
            branch_cnt_reg <= branch_cnt_next;
            miss_cnt_reg   <= miss_cnt_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stg_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_fire)
        begin
            out_pred_reg  <= pred;
            out_taken_reg <= stg_taken_reg;
            out_miss_reg  <= miss;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, miss_cnt_reg, branch_cnt_reg,
                       out_miss_reg, out_taken_reg, out_pred_reg};

    // Checks.
    `include "assert_macros.svh"

    `ASSERT_SAME(a_no_stage_while_clearing, clr_active_reg, !stg_valid_reg,
                 "request in flight during memory clear")
    `ASSERT_SAME(a_miss_le_total, out_valid_reg, miss_cnt_reg <= branch_cnt_reg,
                 "mispredict total above branch total")
    `ASSERT_NEXT(a_fire_loads_output, stg_fire,
                 out_valid_reg && (out_miss_reg == (out_pred_reg ^ out_taken_reg)),
                 "result not loaded consistently")

endmodule

`default_nettype wire
